// File: rtl/krt_pkg.sv
package krt_pkg;

    localparam logic [2:0] MODE_CREATE  = 3'd0;
    localparam logic [2:0] MODE_RESHAPE = 3'd1;
    localparam logic [2:0] MODE_EDIT    = 3'd2;
    localparam logic [2:0] MODE_DELETE  = 3'd3;
    localparam logic [2:0] MODE_OFFSET  = 3'd4;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_DUP       = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    localparam logic [1:0] EV_NONE      = 2'd0;
    localparam logic [1:0] EV_CHANGED   = 2'd1;
    localparam logic [1:0] EV_DELETED   = 2'd2;

    typedef struct packed {
        logic [2:0]  mode;
        logic [15:0] key_id;
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [15:0] size_w;
        logic [15:0] size_h;
        logic [31:0] background;
    } cmd_t;

    typedef struct packed {
        logic [15:0] key;
        logic [31:0] left;
        logic [31:0] top;
        logic [15:0] width;
        logic [15:0] height;
        logic [31:0] color;
    } entry_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [1:0]  event_res;
        logic [15:0] out_id;
        logic [31:0] out_x;
        logic [31:0] out_y;
        logic [15:0] out_w;
        logic [15:0] out_h;
        logic [31:0] out_background;
        logic        last;
    } res_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

// File: rtl/krt_ram.sv
module krt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [AW-1:0]            waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [AW-1:0]            raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

// File: rtl/krt_front.sv
module krt_front (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  krt_pkg::cmd_t in_cmd,
    output logic          q_valid,
    input  logic          q_pop,
    output krt_pkg::cmd_t q_cmd
);
    import krt_pkg::*;

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] fill_reg, fill_next;
    logic       keep, push, pop;

    // unused modes and a zero offset produce nothing, so they never reach the back end
    assign keep = (in_cmd.mode <= MODE_OFFSET) &&
                  !(in_cmd.mode == MODE_OFFSET && in_cmd.pos_x == 32'd0 &&
                    in_cmd.pos_y == 32'd0);
    assign in_ready = (fill_reg != 2'd2);
    assign push     = in_valid && in_ready && keep;
    assign q_valid  = (fill_reg != 2'd0);
    assign pop      = q_pop && q_valid;
    assign q_cmd    = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        fill_next   = fill_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_cmd;
        end
    end
endmodule

// File: rtl/krt_back.sv
module krt_back #(
    parameter int MAX_ENTRIES = 32
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          q_valid,
    input  krt_pkg::cmd_t q_cmd,
    output logic          q_pop,
    output logic          out_valid,
    input  logic          out_ready,
    output krt_pkg::res_t out_res
);
    import krt_pkg::*;

    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_SEARCH  = 3'd1;
    localparam logic [2:0] S_ACT     = 3'd2;
    localparam logic [2:0] S_DEL_RD  = 3'd3;
    localparam logic [2:0] S_DEL_WR  = 3'd4;
    localparam logic [2:0] S_DEL_FIN = 3'd5;
    localparam logic [2:0] S_OFF_RD  = 3'd6;
    localparam logic [2:0] S_OFF_WR  = 3'd7;

    logic [2:0]       state_reg, state_next;
    cmd_t             cmd_reg, cmd_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] scan_reg, scan_next;
    logic             pipe_v_reg, pipe_v_next;
    logic [CNT_W-1:0] pipe_idx_reg, pipe_idx_next;
    logic             hit_reg, hit_next;
    logic [CNT_W-1:0] hit_idx_reg, hit_idx_next;
    entry_t           hit_ent_reg, hit_ent_next;
    logic [CNT_W-1:0] ptr_reg, ptr_next;
    logic             out_v_reg, out_v_next;
    res_t             out_res_reg, out_res_next;

    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr, ram_raddr;
    entry_t           ram_wdata, rd_ent;
    logic [ENTRY_W-1:0] ram_rdata;
    logic             out_free, emit;
    logic [CNT_W-1:0] ptr_inc;
    entry_t           ent;
    res_t             res;

    krt_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(MAX_ENTRIES)
    ) u_ram (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign rd_ent   = entry_t'(ram_rdata);
    assign out_free = !out_v_reg || out_ready;
    assign ptr_inc  = ptr_reg + CNT_W'(1);

    always_comb begin
        case (state_reg)
            S_SEARCH:           ram_raddr = scan_reg[IDX_W-1:0];
            S_DEL_RD, S_DEL_WR: ram_raddr = ptr_inc[IDX_W-1:0];
            S_OFF_RD, S_OFF_WR: ram_raddr = ptr_reg[IDX_W-1:0];
            default:            ram_raddr = scan_reg[IDX_W-1:0];
        endcase
    end

    always_comb begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        cnt_next      = cnt_reg;
        scan_next     = scan_reg;
        pipe_v_next   = 1'b0;
        pipe_idx_next = pipe_idx_reg;
        hit_next      = hit_reg;
        hit_idx_next  = hit_idx_reg;
        hit_ent_next  = hit_ent_reg;
        ptr_next      = ptr_reg;
        q_pop         = 1'b0;
        ram_we        = 1'b0;
        ram_waddr     = ptr_reg[IDX_W-1:0];
        ram_wdata     = rd_ent;
        emit          = 1'b0;
        ent           = hit_ent_reg;
        res           = '0;
        res.out_id    = cmd_reg.key_id;
        res.last      = 1'b1;

        case (state_reg)
            S_IDLE: begin
                if (q_valid) begin
                    q_pop    = 1'b1;
                    cmd_next = q_cmd;
                    if (q_cmd.mode == MODE_OFFSET) begin
                        ptr_next = '0;
                        if (cnt_reg != '0) begin
                            state_next = S_OFF_RD;
                        end
                    end else begin
                        scan_next  = '0;
                        state_next = S_SEARCH;
                    end
                end
            end
            S_SEARCH: begin
                // the key read issued last cycle is compared against the command id
                if (pipe_v_reg && rd_ent.key == cmd_reg.key_id) begin
                    hit_next     = 1'b1;
                    hit_idx_next = pipe_idx_reg;
                    hit_ent_next = rd_ent;
                    state_next   = S_ACT;
                end else if (scan_reg == cnt_reg) begin
                    hit_next   = 1'b0;
                    state_next = S_ACT;
                end else begin
                    pipe_v_next   = 1'b1;
                    pipe_idx_next = scan_reg;
                    scan_next     = scan_reg + CNT_W'(1);
                end
            end
            S_ACT: begin
                if (cmd_reg.mode == MODE_DELETE && hit_reg) begin
                    ptr_next   = hit_idx_reg;
                    state_next = S_DEL_RD;
                end else if (out_free) begin
                    emit       = 1'b1;
                    state_next = S_IDLE;
                    case (cmd_reg.mode)
                        MODE_CREATE: begin
                            if (hit_reg) begin
                                res.status = ST_DUP;
                            end else if (cnt_reg >= CNT_W'(MAX_ENTRIES)) begin
                                res.status = ST_FULL;
                            end else begin
                                ent.key    = cmd_reg.key_id;
                                ent.left   = cmd_reg.pos_x;
                                ent.top    = cmd_reg.pos_y;
                                ent.width  = cmd_reg.size_w;
                                ent.height = cmd_reg.size_h;
                                ent.color  = '0;
                                ram_we     = 1'b1;
                                ram_waddr  = cnt_reg[IDX_W-1:0];
                                cnt_next   = cnt_reg + CNT_W'(1);
                            end
                        end
                        MODE_RESHAPE, MODE_EDIT: begin
                            if (!hit_reg) begin
                                res.status = ST_NOT_FOUND;
                            end else begin
                                if (cmd_reg.mode == MODE_RESHAPE) begin
                                    ent.left   = cmd_reg.pos_x;
                                    ent.top    = cmd_reg.pos_y;
                                    ent.width  = cmd_reg.size_w;
                                    ent.height = cmd_reg.size_h;
                                end else begin
                                    ent.color = cmd_reg.background;
                                end
                                ram_we    = 1'b1;
                                ram_waddr = hit_idx_reg[IDX_W-1:0];
                            end
                        end
                        default: begin
                            res.status = ST_NOT_FOUND;
                        end
                    endcase
                    ram_wdata = ent;
                    if (ram_we) begin
                        res.event_res      = EV_CHANGED;
                        res.out_id         = ent.key;
                        res.out_x          = ent.left;
                        res.out_y          = ent.top;
                        res.out_w          = ent.width;
                        res.out_h          = ent.height;
                        res.out_background = ent.color;
                    end
                end
            end
            S_DEL_RD: begin
                // close the gap one entry at a time
                if (ptr_inc < cnt_reg) begin
                    state_next = S_DEL_WR;
                end else begin
                    state_next = S_DEL_FIN;
                end
            end
            S_DEL_WR: begin
                ram_we     = 1'b1;
                ram_wdata  = rd_ent;
                ptr_next   = ptr_inc;
                state_next = S_DEL_RD;
            end
            S_DEL_FIN: begin
                if (out_free) begin
                    emit          = 1'b1;
                    res.event_res = EV_DELETED;
                    cnt_next      = cnt_reg - CNT_W'(1);
                    state_next    = S_IDLE;
                end
            end
            S_OFF_RD: begin
                state_next = S_OFF_WR;
            end
            S_OFF_WR: begin
                if (out_free) begin
                    ent                = rd_ent;
                    ent.left           = rd_ent.left + cmd_reg.pos_x;
                    ent.top            = rd_ent.top + cmd_reg.pos_y;
                    ram_we             = 1'b1;
                    ram_wdata          = ent;
                    emit               = 1'b1;
                    res.event_res      = EV_CHANGED;
                    res.out_id         = ent.key;
                    res.out_x          = ent.left;
                    res.out_y          = ent.top;
                    res.out_w          = ent.width;
                    res.out_h          = ent.height;
                    res.out_background = ent.color;
                    res.last           = (ptr_inc == cnt_reg);
                    if (ptr_inc == cnt_reg) begin
                        state_next = S_IDLE;
                    end else begin
                        ptr_next   = ptr_inc;
                        state_next = S_OFF_RD;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        out_v_next   = emit ? 1'b1 : (out_ready ? 1'b0 : out_v_reg);
        out_res_next = emit ? res : out_res_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            cnt_reg    <= '0;
            pipe_v_reg <= 1'b0;
            out_v_reg  <= 1'b0;
        end else begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            pipe_v_reg <= pipe_v_next;
            out_v_reg  <= out_v_next;
        end
        cmd_reg      <= cmd_next;
        scan_reg     <= scan_next;
        pipe_idx_reg <= pipe_idx_next;
        hit_reg      <= hit_next;
        hit_idx_reg  <= hit_idx_next;
        hit_ent_reg  <= hit_ent_next;
        ptr_reg      <= ptr_next;
        out_res_reg  <= out_res_next;
    end

    assign out_valid = out_v_reg;
    assign out_res   = out_res_reg;
endmodule

// File: rtl/keyed_rect_table_core.sv
// Keyed rectangle table: an insertion-ordered table of up to MAX_ENTRIES entries held in one
// RAM and worked on by one read and one write a cycle. Create, reshape, edit and delete first
// scan the table by id at one entry per cycle and then give one beat; before its beat,
// delete moves every later entry up one place. Offset all reads, adds and writes back each
// entry and gives one beat each, with tlast on the final one. A two-deep command queue sits
// in front, so the input side keeps accepting until both of its slots are full; unused modes
// and a zero offset are accepted and dropped. The output register lets the next command
// start while a finished beat waits.
module keyed_rect_table_core #(
    parameter int MAX_ENTRIES = 32
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // key_id[15:0], pos_x[47:16], pos_y[79:48], size_w[95:80], size_h[111:96],
    // background[143:112]
    input  logic [143:0] s_axis_tdata,
    // mode[2:0]
    input  logic [2:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // out_id[15:0], out_x[47:16], out_y[79:48], out_w[95:80], out_h[111:96],
    // out_background[143:112]
    output logic [143:0] m_axis_tdata,
    // status[1:0], event_res[3:2]
    output logic [3:0]   m_axis_tuser,
    output logic         m_axis_tlast
);
    import krt_pkg::*;

    cmd_t in_cmd, q_cmd;
    res_t res;
    logic q_valid, q_pop;

    assign in_cmd.mode       = s_axis_tuser;
    assign in_cmd.key_id     = s_axis_tdata[15:0];
    assign in_cmd.pos_x      = s_axis_tdata[47:16];
    assign in_cmd.pos_y      = s_axis_tdata[79:48];
    assign in_cmd.size_w     = s_axis_tdata[95:80];
    assign in_cmd.size_h     = s_axis_tdata[111:96];
    assign in_cmd.background = s_axis_tdata[143:112];

    krt_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_valid(s_axis_tvalid),
        .in_ready(s_axis_tready),
        .in_cmd  (in_cmd),
        .q_valid (q_valid),
        .q_pop   (q_pop),
        .q_cmd   (q_cmd)
    );

    krt_back #(
        .MAX_ENTRIES(MAX_ENTRIES)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd),
        .q_pop    (q_pop),
        .out_valid(m_axis_tvalid),
        .out_ready(m_axis_tready),
        .out_res  (res)
    );

    assign m_axis_tdata = {res.out_background, res.out_h, res.out_w, res.out_y, res.out_x,
                           res.out_id};
    assign m_axis_tuser = {res.event_res, res.status};
    assign m_axis_tlast = res.last;
endmodule

// File: rtl/keyed_rect_table_core_chk.sv
module keyed_rect_table_core_chk (
    input logic         aclk,
    input logic         aresetn,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [143:0] m_axis_tdata,
    input logic [3:0]   m_axis_tuser,
    input logic         m_axis_tlast
);
    import krt_pkg::*;

    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output beat dropped while stalled");

    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=>
            $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("output beat changed while stalled");

    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("output beat right after reset");

    // a failed command is a single beat with no event
    a_fail_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser[1:0] != ST_OK |->
            m_axis_tuser[3:2] == EV_NONE && m_axis_tlast && m_axis_tdata[143:16] == '0)
        else $error("bad failure beat");

    a_delete_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser[3:2] == EV_DELETED |->
            m_axis_tuser[1:0] == ST_OK && m_axis_tlast && m_axis_tdata[143:16] == '0)
        else $error("bad delete beat");
endmodule

bind keyed_rect_table_core keyed_rect_table_core_chk u_chk (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
);

// File: tb/sv/tb_keyed_rect_table_core.sv
`timescale 1ns / 1ps

module tb_keyed_rect_table_core;
    import krt_pkg::*;

    localparam int TABLE_DEPTH = 32;
    localparam int STALL_LIMIT = 20000;

    logic         aclk;
    logic         aresetn;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [143:0] s_axis_tdata;
    logic [2:0]   s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [143:0] m_axis_tdata;
    logic [3:0]   m_axis_tuser;
    logic         m_axis_tlast;

    keyed_rect_table_core #(.MAX_ENTRIES(TABLE_DEPTH)) u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // shadow copy of the table
    entry_t tbl [TABLE_DEPTH];
    int     tbl_count;
    res_t   pending_beats [$];

    int  mismatches;
    int  beats_seen;
    int  cmds_sent;
    int  idle_cycles;
    bit  no_idle;
    bit  timed_out;

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    function automatic int find_key(logic [15:0] id);
        for (int i = 0; i < tbl_count; i++)
            if (tbl[i].key == id) return i;
        return -1;
    endfunction

    function automatic res_t entry_beat(int i, logic lst);
        res_t r;
        r.status = ST_OK;
        r.event_res = EV_CHANGED;
        r.out_id = tbl[i].key;
        r.out_x = tbl[i].left;
        r.out_y = tbl[i].top;
        r.out_w = tbl[i].width;
        r.out_h = tbl[i].height;
        r.out_background = tbl[i].color;
        r.last = lst;
        return r;
    endfunction

    function automatic res_t bare_beat(logic [1:0] st, logic [1:0] ev, logic [15:0] id);
        res_t r;
        r = '0;
        r.status = st;
        r.event_res = ev;
        r.out_id = id;
        r.last = 1'b1;
        return r;
    endfunction

    // updates the shadow table and queues the beats one command produces
    function automatic void apply_cmd(cmd_t c);
        int idx;
        idx = find_key(c.key_id);
        case (c.mode)
            MODE_CREATE: begin
                if (idx >= 0) pending_beats.push_back(bare_beat(ST_DUP, EV_NONE, c.key_id));
                else if (tbl_count >= TABLE_DEPTH)
                    pending_beats.push_back(bare_beat(ST_FULL, EV_NONE, c.key_id));
                else begin
                    tbl[tbl_count] = '{c.key_id, c.pos_x, c.pos_y, c.size_w, c.size_h, 32'd0};
                    tbl_count++;
                    pending_beats.push_back(entry_beat(tbl_count - 1, 1'b1));
                end
            end
            MODE_RESHAPE, MODE_EDIT, MODE_DELETE: begin
                if (idx < 0) begin
                    pending_beats.push_back(bare_beat(ST_NOT_FOUND, EV_NONE, c.key_id));
                end else if (c.mode == MODE_RESHAPE) begin
                    tbl[idx].left = c.pos_x;
                    tbl[idx].top = c.pos_y;
                    tbl[idx].width = c.size_w;
                    tbl[idx].height = c.size_h;
                    pending_beats.push_back(entry_beat(idx, 1'b1));
                end else if (c.mode == MODE_EDIT) begin
                    tbl[idx].color = c.background;
                    pending_beats.push_back(entry_beat(idx, 1'b1));
                end else begin
                    for (int i = idx; i + 1 < tbl_count; i++) tbl[i] = tbl[i + 1];
                    tbl_count--;
                    pending_beats.push_back(bare_beat(ST_OK, EV_DELETED, c.key_id));
                end
            end
            MODE_OFFSET: begin
                if (!(c.pos_x == 0 && c.pos_y == 0) && tbl_count != 0)
                    for (int i = 0; i < tbl_count; i++) begin
                        tbl[i].left = tbl[i].left + c.pos_x;
                        tbl[i].top = tbl[i].top + c.pos_y;
                        pending_beats.push_back(entry_beat(i, i + 1 == tbl_count));
                    end
            end
            default: ;
        endcase
    endfunction

    // tvalid stays high after a handshake until an idle burst or a drain drops it
    task automatic send_cmd(cmd_t c);
        if (!no_idle && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= c.mode;
        s_axis_tdata <= {c.background, c.size_h, c.size_w, c.pos_y, c.pos_x, c.key_id};
        do @(posedge aclk); while (!s_axis_tready);
        apply_cmd(c);
        cmds_sent++;
    endtask

    function automatic cmd_t mk(logic [2:0] m, logic [15:0] id, logic [31:0] x,
                                logic [31:0] y, logic [15:0] w, logic [15:0] h,
                                logic [31:0] bg);
        cmd_t c;
        c = '{m, id, x, y, w, h, bg};
        return c;
    endfunction

    function automatic logic [31:0] rnd32();
        case ($urandom_range(0, 4))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    // picks an id that is usually live in the table
    function automatic logic [15:0] pick_id();
        if (tbl_count > 0 && $urandom_range(0, 3) != 0)
            return tbl[$urandom_range(0, tbl_count - 1)].key;
        return 16'($urandom_range(0, 47));
    endfunction

    task automatic wait_drain();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_beats.size() != 0 && !timed_out) @(posedge aclk);
    endtask

    // receiver: stall bursts and beat checks
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                res_t got, want;
                got.status = m_axis_tuser[1:0];
                got.event_res = m_axis_tuser[3:2];
                got.out_id = m_axis_tdata[15:0];
                got.out_x = m_axis_tdata[47:16];
                got.out_y = m_axis_tdata[79:48];
                got.out_w = m_axis_tdata[95:80];
                got.out_h = m_axis_tdata[111:96];
                got.out_background = m_axis_tdata[143:112];
                got.last = m_axis_tlast;
                beats_seen++;
                if (pending_beats.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected beat %h", got);
                end else begin
                    want = pending_beats.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected %h actual %h", want, got);
                    end
                end
            end
            if (no_idle) m_axis_tready <= 1'b1;
            else if (idle_cycles > 0) begin
                m_axis_tready <= 1'b0;
                idle_cycles <= idle_cycles - 1;
            end else if ($urandom_range(0, 5) == 0) begin
                m_axis_tready <= 1'b0;
                idle_cycles <= $urandom_range(0, 4);
            end else m_axis_tready <= 1'b1;
        end
    end

    // watchdog on cycles without any beat
    int quiet;
    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet <= 0;
        else if (aresetn) quiet <= quiet + 1;
        if (quiet >= STALL_LIMIT && !timed_out) begin
            timed_out = 1'b1;
            $display("timeout waiting for a beat");
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic test_directed();
        send_cmd(mk(MODE_OFFSET, 16'd0, 32'd5, 32'd5, 16'd0, 16'd0, 32'd0)); // empty table
        send_cmd(mk(MODE_RESHAPE, 16'hffff, 32'd1, 32'd1, 16'd1, 16'd1, 32'd0));
        send_cmd(mk(MODE_EDIT, 16'd0, 32'd0, 32'd0, 16'd0, 16'd0, 32'hffff_ffff));
        send_cmd(mk(MODE_DELETE, 16'd7, 32'd0, 32'd0, 16'd0, 16'd0, 32'd0));
        send_cmd(mk(MODE_CREATE, 16'd0, 32'h8000_0000, 32'h7fff_ffff, 16'hffff, 16'd0,
                    32'hffff_ffff));
        send_cmd(mk(MODE_CREATE, 16'hffff, 32'hffff_ffff, 32'h8000_0000, 16'd0, 16'hffff,
                    32'd0));
        send_cmd(mk(MODE_CREATE, 16'd0, 32'd1, 32'd2, 16'd3, 16'd4, 32'd0)); // duplicate
        send_cmd(mk(MODE_EDIT, 16'hffff, 32'd0, 32'd0, 16'd0, 16'd0, 32'hffff_ffff));
        send_cmd(mk(MODE_RESHAPE, 16'd0, 32'h7fff_ffff, 32'hffff_ffff, 16'h5555, 16'haaaa,
                    32'd0));
        send_cmd(mk(MODE_OFFSET, 16'hffff, 32'd1, 32'h8000_0000, 16'hffff, 16'hffff,
                    32'hffff_ffff)); // wraps
        send_cmd(mk(MODE_OFFSET, 16'd0, 32'd0, 32'd0, 16'd0, 16'd0, 32'd0)); // zero offset
        send_cmd(mk(MODE_OFFSET, 16'd0, 32'd0, 32'hffff_ffff, 16'd0, 16'd0, 32'd0));
        send_cmd(mk(3'd5, 16'd0, 32'd0, 32'd0, 16'd0, 16'd0, 32'd0));
        send_cmd(mk(3'd6, 16'd0, 32'd1, 32'd1, 16'd0, 16'd0, 32'd0));
        send_cmd(mk(3'd7, 16'hffff, 32'd0, 32'd0, 16'd0, 16'd0, 32'd0));
        send_cmd(mk(MODE_DELETE, 16'd0, 32'd0, 32'd0, 16'd0, 16'd0, 32'd0)); // closes gap
        send_cmd(mk(MODE_DELETE, 16'hffff, 32'd0, 32'd0, 16'd0, 16'd0, 32'd0));
        wait_drain();
    endtask

    task automatic test_full_table();
        for (int i = 0; i < TABLE_DEPTH; i++)
            send_cmd(mk(MODE_CREATE, 16'(100 + i), $urandom, $urandom, 16'($urandom),
                        16'($urandom), 32'd0));
        send_cmd(mk(MODE_CREATE, 16'd100, 32'd0, 32'd0, 16'd0, 16'd0, 32'd0)); // dup first
        send_cmd(mk(MODE_CREATE, 16'd999, 32'd0, 32'd0, 16'd0, 16'd0, 32'd0)); // full
        send_cmd(mk(MODE_OFFSET, 16'd0, 32'hffff_fff0, 32'd3, 16'd0, 16'd0, 32'd0));
        send_cmd(mk(MODE_DELETE, 16'd131, 32'd0, 32'd0, 16'd0, 16'd0, 32'd0)); // last slot
        send_cmd(mk(MODE_DELETE, 16'd100, 32'd0, 32'd0, 16'd0, 16'd0, 32'd0)); // first slot
        while (tbl_count > 0)
            send_cmd(mk(MODE_DELETE, tbl[$urandom_range(0, tbl_count - 1)].key,
                        32'd0, 32'd0, 16'd0, 16'd0, 32'd0));
        wait_drain();
    endtask

    task automatic test_random(int n);
        cmd_t c;
        int   r;
        for (int k = 0; k < n && !timed_out; k++) begin
            if (k > n * 4 / 5) no_idle = 1'b1;
            r = $urandom_range(0, 99);
            c.key_id = pick_id();
            c.pos_x = rnd32();
            c.pos_y = rnd32();
            c.size_w = 16'($urandom);
            c.size_h = 16'($urandom);
            c.background = rnd32();
            if (r < 30 + (tbl_count < 8 ? 20 : 0)) c.mode = MODE_CREATE;
            else if (r < 50) c.mode = MODE_RESHAPE;
            else if (r < 66) c.mode = MODE_EDIT;
            else if (r < 82) c.mode = MODE_DELETE;
            else if (r < 96) begin
                c.mode = MODE_OFFSET;
                if ($urandom_range(0, 5) == 0) begin
                    c.pos_x = 32'd0;
                    c.pos_y = 32'd0;
                end
            end else c.mode = 3'($urandom_range(5, 7));
            send_cmd(c);
        end
        wait_drain();
    endtask

    initial begin
        aresetn = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        tbl_count = 0;
        mismatches = 0;
        beats_seen = 0;
        cmds_sent = 0;
        no_idle = 1'b0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_full_table();
        test_random(240);
        repeat (200) @(posedge aclk);
        $display("covered %0d commands and %0d result beats: all modes, failures,",
                 cmds_sent, beats_seen);
        $display("full table, wrapping offsets and stalls on both sides");
        if (mismatches == 0 && pending_beats.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("%0d mismatches, %0d beats missing", mismatches, pending_beats.size());
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule

// File: keyed_rect_table_core.f
rtl/krt_pkg.sv
rtl/krt_ram.sv
rtl/krt_front.sv
rtl/krt_back.sv
rtl/keyed_rect_table_core.sv
rtl/keyed_rect_table_core_chk.sv
tb/sv/tb_keyed_rect_table_core.sv
